FILE: rtl/dhcd_pkg.sv
// shared types, codes and reset values for the directional hysteresis change detector
package dhcd_pkg;

    localparam int unsigned ValW = 10;
    localparam int unsigned CfgIdxW = 2;

    // direction codes
    localparam logic [1:0] DIR_WAIT = 2'd0;
    localparam logic [1:0] DIR_RISE = 2'd1;
    localparam logic [1:0] DIR_FALL = 2'd2;

    // register indexes on the config port
    localparam logic [CfgIdxW-1:0] CFG_BIG_DELTA    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_LITTLE_DELTA = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MEDIUM_DELTA = 2'd2;

    // reset values: 1024 / 20, 4 and twice the little delta
    localparam logic [ValW-1:0] BIG_DELTA_RST    = ValW'(1024 / 20);
    localparam logic [ValW-1:0] LITTLE_DELTA_RST = ValW'(4);
    localparam logic [ValW-1:0] MEDIUM_DELTA_RST = ValW'(4 * 2);

    typedef logic [ValW-1:0] val_t;

    typedef struct packed {
        val_t big_delta;
        val_t little_delta;
        val_t medium_delta;
    } cfg_t;

    typedef struct packed {
        logic       accept;
        logic [1:0] dir_next;
    } decision_t;

endpackage

FILE: rtl/directional_hysteresis_change_detector.sv
// top level: input register, decision logic, state and result register
//
//   channel  | handshake               | payload
//   ---------+-------------------------+--------------------------------
//   input    | in_valid / in_stall     | reading, restart
//   output   | out_valid / out_stall   | changed, official_value
//   config   | cfg_we                  | cfg_index, cfg_data
//
// one transaction per cycle sustained while out_stall stays low; a sample
// passes the input register, then the result register.
// the held value and direction update in the same edge that loads the
// result register, so the next sample is judged against them.
// reset clears valids, direction and held value, thresholds go to defaults.
// a stalled result holds the input register; in_stall rises only then.
module directional_hysteresis_change_detector
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [dhcd_pkg::ValW-1:0]        reading,
    input  logic                             restart,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             changed,
    output logic [dhcd_pkg::ValW-1:0]        official_value,
    input  logic                             cfg_we,
    input  logic [dhcd_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [dhcd_pkg::ValW-1:0]        cfg_data
);

    dhcd_pkg::cfg_t             cfg;
    dhcd_pkg::decision_t        decision;

    logic                       s1_valid_reg;
    logic [dhcd_pkg::ValW-1:0]  reading_reg;
    logic                       restart_reg;
    logic                       out_valid_reg;
    logic                       changed_reg;
    logic [dhcd_pkg::ValW-1:0]  official_reg;
    logic [dhcd_pkg::ValW-1:0]  held_reg;
    logic [dhcd_pkg::ValW-1:0]  held_next;
    logic [1:0]                 dir_reg;
    logic                       advance;
    logic                       in_take;

    dhcd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dhcd_judge u_judge
    (
        .reading  (reading_reg),
        .restart  (restart_reg),
        .held     (held_reg),
        .dir      (dir_reg),
        .cfg      (cfg),
        .decision (decision)
    );

    // pipeline control
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign held_next = decision.accept ? reading_reg : held_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            reading_reg <= reading;
            restart_reg <= restart;
        end
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            dir_reg  <= dhcd_pkg::DIR_WAIT;
        end
        else if (advance)
        begin
            held_reg <= held_next;
            dir_reg  <= decision.dir_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            changed_reg  <= decision.accept && !restart_reg;
            official_reg <= held_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign changed        = changed_reg;
    assign official_value = official_reg;

    // the shown result always matches the held state
    a_held_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> official_reg == held_reg)
        else $error("official value differs from held state");

    // a reported change leaves a direction of travel
    a_change_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && changed_reg) |->
            (dir_reg == dhcd_pkg::DIR_RISE || dir_reg == dhcd_pkg::DIR_FALL))
        else $error("change reported while waiting");

    // a restart sample never reports a change
    a_restart_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && restart_reg) |=> !changed_reg)
        else $error("change reported on restart sample");

    // the input side only stalls behind a held sample
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

endmodule

FILE: rtl/dhcd_cfg.sv
// configuration registers for the three step thresholds
module dhcd_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dhcd_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [dhcd_pkg::ValW-1:0]        cfg_data,
    output dhcd_pkg::cfg_t                   cfg
);

    dhcd_pkg::cfg_t cfg_reg;
    dhcd_pkg::cfg_t cfg_next;

    // decode the write, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dhcd_pkg::CFG_BIG_DELTA:    cfg_next.big_delta    = cfg_data;
                dhcd_pkg::CFG_LITTLE_DELTA: cfg_next.little_delta = cfg_data;
                dhcd_pkg::CFG_MEDIUM_DELTA: cfg_next.medium_delta = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.big_delta    <= dhcd_pkg::BIG_DELTA_RST;
            cfg_reg.little_delta <= dhcd_pkg::LITTLE_DELTA_RST;
            cfg_reg.medium_delta <= dhcd_pkg::MEDIUM_DELTA_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/dhcd_judge.sv
// decision logic: judges one reading against the held value and direction
module dhcd_judge
(
    input  logic [dhcd_pkg::ValW-1:0] reading,
    input  logic                      restart,
    input  logic [dhcd_pkg::ValW-1:0] held,
    input  logic [1:0]                dir,
    input  dhcd_pkg::cfg_t            cfg,
    output dhcd_pkg::decision_t       decision
);

    localparam int unsigned SumW = dhcd_pkg::ValW + 1;

    logic [1:0]      dir_eff;
    logic [SumW-1:0] r_ext;
    logic [SumW-1:0] h_ext;
    logic            up_little;
    logic            up_medium;
    logic            up_big;
    logic            dn_little;
    logic            dn_medium;
    logic            dn_big;

    // compare as r > h + d and r + d < h so nothing goes negative
    always_comb
    begin
        r_ext     = {1'b0, reading};
        h_ext     = {1'b0, held};
        up_little = r_ext > (h_ext + {1'b0, cfg.little_delta});
        up_medium = r_ext > (h_ext + {1'b0, cfg.medium_delta});
        up_big    = r_ext > (h_ext + {1'b0, cfg.big_delta});
        dn_little = (r_ext + {1'b0, cfg.little_delta}) < h_ext;
        dn_medium = (r_ext + {1'b0, cfg.medium_delta}) < h_ext;
        dn_big    = (r_ext + {1'b0, cfg.big_delta}) < h_ext;
    end

    // restart judges the reading as in the waiting state
    assign dir_eff = restart ? dhcd_pkg::DIR_WAIT : dir;

    always_comb
    begin
        decision.accept   = 1'b0;
        decision.dir_next = dir_eff;
        case (dir_eff)
            dhcd_pkg::DIR_RISE:
            begin
                if (up_little)
                begin
                    decision.accept = 1'b1;
                end
                else if (dn_medium)
                begin
                    decision.accept   = 1'b1;
                    decision.dir_next = dhcd_pkg::DIR_FALL;
                end
            end
            dhcd_pkg::DIR_FALL:
            begin
                if (dn_little)
                begin
                    decision.accept = 1'b1;
                end
                else if (up_medium)
                begin
                    decision.accept   = 1'b1;
                    decision.dir_next = dhcd_pkg::DIR_RISE;
                end
            end
            default:
            begin
                // waiting, and the unused code behaves the same
                if (up_big)
                begin
                    decision.accept   = 1'b1;
                    decision.dir_next = dhcd_pkg::DIR_RISE;
                end
                else if (dn_big)
                begin
                    decision.accept   = 1'b1;
                    decision.dir_next = dhcd_pkg::DIR_FALL;
                end
            end
        endcase
    end

endmodule
